// ----- rtl/fccm_pkg.sv -----
package fccm_pkg;

  // Field widths
  localparam int EW     = 16;  // table entry
  localparam int ACT_W  = 3;
  localparam int CLU_W  = 12;
  localparam int ST_W   = 2;
  localparam int CFG_W  = 13;
  localparam int DATA_W = 16;  // tdata on both sides

  // Actions
  localparam logic [ACT_W-1:0] ACT_FORMAT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_EXTEND = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FREE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SUCC   = 3'd5;

  // Table entry codes
  localparam logic [EW-1:0] CODE_FREE = 16'd1;
  localparam logic [EW-1:0] CODE_END  = 16'd2;
  localparam logic [EW-1:0] CODE_RSVD = 16'd3;
  localparam logic [EW-1:0] CODE_DIR  = 16'd4;

  localparam int RESERVED_COUNT = 32;
  localparam int FIRST_DATA     = 33;
  localparam int CIU_RESET      = 4096;

  // Result status
  localparam logic [ST_W-1:0] ST_OK          = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL        = 2'd1;
  localparam logic [ST_W-1:0] ST_UNFORMATTED = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERRUN     = 2'd3;

  // Scan pointer operations
  localparam logic [1:0] ADDR_HOLD  = 2'd0;
  localparam logic [1:0] ADDR_ZERO  = 2'd1;
  localparam logic [1:0] ADDR_FIRST = 2'd2;
  localparam logic [1:0] ADDR_INC   = 2'd3;

  // Table write operations
  localparam logic [2:0] WR_NONE = 3'd0;
  localparam logic [2:0] WR_ZERO = 3'd1;
  localparam logic [2:0] WR_FMT  = 3'd2;
  localparam logic [2:0] WR_LINK = 3'd3;
  localparam logic [2:0] WR_END  = 3'd4;
  localparam logic [2:0] WR_FREE = 3'd5;

  // Table read operations
  localparam logic [1:0] RD_NONE    = 2'd0;
  localparam logic [1:0] RD_ADDR    = 2'd1;
  localparam logic [1:0] RD_CLUSTER = 2'd2;
  localparam logic [1:0] RD_DATA    = 2'd3;

  // Result cluster source
  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_FOUND = 2'd1;
  localparam logic [1:0] RES_DATA  = 2'd2;

  typedef struct packed {
    logic            capture;
    logic [1:0]      addr_op;
    logic [2:0]      wr_op;
    logic [1:0]      rd_op;
    logic            walk_init;
    logic            walk_step;
    logic            chk_clr;
    logic            fmt_set;
    logic            fmt_clr;
    logic            found_ld;
    logic            res_ld;
    logic [ST_W-1:0] res_status;
    logic [1:0]      res_sel;
    logic            out_ld;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             formatted;
    logic             clu_in_range;
    logic             fmt_last;
    logic             chk_issue;
    logic             chk_last;
    logic             chk_fail;
    logic             scan_issue;
    logic             scan_hit;
    logic             rd_vld;
    logic             walk_start_over;
    logic             walk_end;
    logic             walk_over;
    logic             clear_last;
    logic             out_free;
  } stat_t;

endpackage

// ----- rtl/fccm_dp.sv -----
module fccm_dp #(
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [fccm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [fccm_pkg::DATA_W-1:0] s_tdata,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [fccm_pkg::DATA_W-1:0] m_tdata,
  input  fccm_pkg::cmd_t              cmd,
  output fccm_pkg::stat_t             stat
);
  import fccm_pkg::*;

  localparam int AW = $clog2(MAX_CLUSTERS);
  localparam int NW = $clog2(MAX_CLUSTERS + 1);

  logic [EW-1:0]    mem [MAX_CLUSTERS];

  logic [CFG_W-1:0] clusters_in_use;
  logic [NW-1:0]    n;
  logic [ACT_W-1:0] act;
  logic [CLU_W-1:0] clu;
  logic [AW:0]      addr;
  logic [AW-1:0]    cur;
  logic [NW-1:0]    cnt;
  logic [AW-1:0]    found;
  logic [EW-1:0]    rd_data;
  logic [AW-1:0]    rd_addr;
  logic             rd_vld;
  logic             chk_bad;
  logic             formatted;
  logic [ST_W-1:0]  res_status;
  logic [CLU_W-1:0] res_cluster;
  logic             out_valid;
  logic [DATA_W-1:0] out_data;

  logic             we;
  logic [AW-1:0]    wa;
  logic [EW-1:0]    wd;
  logic             re;
  logic [AW-1:0]    ra;
  logic             mismatch;

  // working count = min(register, table depth)
  always_comb begin
    if (32'(clusters_in_use) > 32'(MAX_CLUSTERS)) begin
      n = NW'(MAX_CLUSTERS);
    end else begin
      n = NW'(clusters_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= CFG_W'(CIU_RESET);
    end else if (cfg_wen) begin
      clusters_in_use <= cfg_wdata;
    end
  end

  // write port select
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    unique case (cmd.wr_op)
      WR_NONE: begin
      end
      WR_ZERO: begin
        we = 1'b1;
        wa = addr[AW-1:0];
      end
      WR_FMT: begin
        we = 1'b1;
        wa = addr[AW-1:0];
        if (32'(addr) < RESERVED_COUNT) begin
          wd = CODE_RSVD;
        end else if (32'(addr) == RESERVED_COUNT) begin
          wd = CODE_DIR;
        end else begin
          wd = CODE_FREE;
        end
      end
      WR_LINK: begin
        we = 1'b1;
        wa = AW'(clu);
        wd = EW'(found);
      end
      WR_END: begin
        we = 1'b1;
        wa = found;
        wd = CODE_END;
      end
      WR_FREE: begin
        we = 1'b1;
        wa = cur;
        wd = CODE_FREE;
      end
      default: begin
      end
    endcase
  end

  // read port select
  always_comb begin
    re = 1'b1;
    ra = '0;
    unique case (cmd.rd_op)
      RD_NONE:    re = 1'b0;
      RD_ADDR:    ra = addr[AW-1:0];
      RD_CLUSTER: ra = AW'(clu);
      RD_DATA:    ra = AW'(rd_data);
      default:    re = 1'b0;
    endcase
  end

  // table: one write and one registered read per cycle, write data forwarded
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= (we && (wa == ra)) ? wd : mem[ra];
      rd_addr <= ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= re;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      unique case (cmd.addr_op)
        ADDR_HOLD:  addr <= addr;
        ADDR_ZERO:  addr <= '0;
        ADDR_FIRST: addr <= (AW+1)'(FIRST_DATA);
        ADDR_INC:   addr <= addr + 1'b1;
        default:    addr <= addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= s_tdata[ACT_W-1:0];
      clu <= s_tdata[ACT_W +: CLU_W];
    end
    if (cmd.walk_init) begin
      cur <= AW'(clu);
      cnt <= '0;
    end else if (cmd.walk_step) begin
      cur <= AW'(rd_data);
      cnt <= cnt + 1'b1;
    end
    if (cmd.found_ld) begin
      found <= rd_addr;
    end
    if (cmd.chk_clr) begin
      chk_bad <= 1'b0;
    end else if (rd_vld && mismatch) begin
      chk_bad <= 1'b1;
    end
    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_sel)
        RES_ZERO:  res_cluster <= '0;
        RES_FOUND: res_cluster <= CLU_W'(found);
        RES_DATA:  res_cluster <= rd_data[CLU_W-1:0];
        default:   res_cluster <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      formatted <= 1'b1;
    end else if (cmd.fmt_set) begin
      formatted <= 1'b1;
    end else if (cmd.fmt_clr) begin
      formatted <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data <= {(DATA_W-CLU_W-ST_W)'(0), res_cluster, res_status};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign mismatch = ((32'(rd_addr) < RESERVED_COUNT) && (rd_data != CODE_RSVD)) ||
                    ((32'(rd_addr) == RESERVED_COUNT) && (rd_data != CODE_DIR));

  always_comb begin
    stat.act             = act;
    stat.formatted       = formatted;
    stat.clu_in_range    = 32'(clu) < 32'(MAX_CLUSTERS);
    stat.fmt_last        = (32'(addr) >= RESERVED_COUNT) &&
                           (32'(addr) + 32'd1 >= 32'(n));
    stat.chk_issue       = 32'(addr) <= RESERVED_COUNT;
    stat.chk_last        = rd_vld && (32'(rd_addr) == RESERVED_COUNT);
    stat.chk_fail        = chk_bad || (rd_vld && mismatch);
    stat.scan_issue      = 32'(addr) < 32'(n);
    stat.scan_hit        = rd_vld && (rd_data == CODE_FREE);
    stat.rd_vld          = rd_vld;
    stat.walk_start_over = (32'(clu) >= 32'(MAX_CLUSTERS)) || (32'(cnt) >= 32'(n));
    stat.walk_end        = rd_data == CODE_END;
    stat.walk_over       = (32'(rd_data) >= 32'(MAX_CLUSTERS)) ||
                           (32'(cnt) + 32'd1 >= 32'(n));
    stat.clear_last      = addr[AW-1:0] == AW'(MAX_CLUSTERS - 1);
    stat.out_free        = !out_valid || m_tready;
  end

endmodule

// ----- rtl/fccm_ctrl.sv -----
module fccm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  fccm_pkg::stat_t stat,
  output fccm_pkg::cmd_t  cmd
);
  import fccm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_FMT   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_ENDW  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FWR   = 4'd9;
  localparam logic [3:0] S_SUCC  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_op   = WR_ZERO;
        cmd.addr_op = ADDR_INC;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_sel    = RES_ZERO;
        state_next     = S_DONE;
        unique case (stat.act)
          ACT_FORMAT: begin
            cmd.addr_op = ADDR_ZERO;
            state_next  = S_FMT;
          end
          ACT_CHECK: begin
            cmd.addr_op = ADDR_ZERO;
            cmd.chk_clr = 1'b1;
            state_next  = S_CHK;
          end
          ACT_ALLOC, ACT_EXTEND: begin
            if (!stat.formatted) begin
              cmd.res_status = ST_UNFORMATTED;
            end else begin
              cmd.addr_op = ADDR_FIRST;
              state_next  = S_SCAN;
            end
          end
          ACT_FREE: begin
            cmd.walk_init = 1'b1;
            state_next    = S_FRD;
          end
          ACT_SUCC: begin
            if (stat.clu_in_range) begin
              cmd.rd_op  = RD_CLUSTER;
              state_next = S_SUCC;
            end
          end
          default: begin
          end
        endcase
      end
      S_FMT: begin
        cmd.wr_op   = WR_FMT;
        cmd.addr_op = ADDR_INC;
        if (stat.fmt_last) begin
          cmd.fmt_set    = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_DONE;
        end
      end
      S_CHK: begin
        if (stat.chk_issue) begin
          cmd.rd_op   = RD_ADDR;
          cmd.addr_op = ADDR_INC;
        end
        if (stat.chk_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = RES_ZERO;
          if (stat.chk_fail) begin
            cmd.fmt_clr    = 1'b1;
            cmd.res_status = ST_UNFORMATTED;
          end else begin
            cmd.fmt_set    = 1'b1;
            cmd.res_status = ST_OK;
          end
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        // reads go out one per cycle; data is checked in the cycle after its read
        if (stat.scan_hit) begin
          cmd.found_ld = 1'b1;
          state_next   = S_LINK;
        end else if (!stat.rd_vld && !stat.scan_issue) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_FULL;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_DONE;
        end else if (stat.scan_issue) begin
          cmd.rd_op   = RD_ADDR;
          cmd.addr_op = ADDR_INC;
        end
      end
      S_LINK: begin
        if (stat.act == ACT_EXTEND && stat.clu_in_range) begin
          cmd.wr_op = WR_LINK;
        end
        state_next = S_ENDW;
      end
      S_ENDW: begin
        cmd.wr_op      = WR_END;
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_sel    = RES_FOUND;
        state_next     = S_DONE;
      end
      S_FRD: begin
        if (stat.walk_start_over) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OVERRUN;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_DONE;
        end else begin
          cmd.rd_op  = RD_CLUSTER;
          state_next = S_FWR;
        end
      end
      S_FWR: begin
        // release current entry, follow its old link in the same cycle
        cmd.wr_op     = WR_FREE;
        cmd.walk_step = 1'b1;
        if (stat.walk_end) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_DONE;
        end else if (stat.walk_over) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_OVERRUN;
          cmd.res_sel    = RES_ZERO;
          state_next     = S_DONE;
        end else begin
          cmd.rd_op = RD_DATA;
        end
      end
      S_SUCC: begin
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_sel    = RES_DATA;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fat_cluster_chain_manager.sv -----
// Cluster chain manager for a file allocation table held in on-chip memory.
// Input channel s_*: one item = {cluster, action}; actions are format, check,
// allocate, extend, free and successor lookup. Output channel m_*: one result
// item per input item = {result_cluster, status}, in input order.
// Config: cfg_wen/cfg_wdata write clusters_in_use (entries backed by the
// device); write it only while the block is idle.
// Work per item: allocate/extend scan the table one entry per cycle from
// cluster 33, and free follows the chain one link per cycle.
// One item is worked on at a time.
// Reset: synchronous, active high. After reset the table is swept to zero,
// one entry per cycle with s_tready low; config writes are still taken.
// The formatted flag comes out of reset set.
// The result sits in an output register: a new item is accepted while it
// waits, and the controller holds the next result until m_tready frees it.
module fat_cluster_chain_manager #(
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [fccm_pkg::CFG_W-1:0]  cfg_wdata,   // clusters_in_use
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fccm_pkg::DATA_W-1:0] s_tdata,     // [2:0] action, [14:3] cluster, [15] 0
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fccm_pkg::DATA_W-1:0] m_tdata      // [1:0] status, [13:2] result_cluster,
                                                   // [15:14] 0
);
  import fccm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: one state per phase of each action
  fccm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memory, scan/walk pointers, config register, output register
  fccm_dp #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- rtl/fccm_checker.sv -----
module fccm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [fccm_pkg::DATA_W-1:0] s_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [fccm_pkg::DATA_W-1:0] m_tdata
);
  import fccm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset starts the clearing sweep with nothing in or out
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("ports active right after reset");

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // error results carry no cluster
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[ST_W-1:0] != ST_OK) |-> m_tdata[ST_W +: CLU_W] == '0)
    else $error("error result with nonzero cluster");

endmodule

bind fat_cluster_chain_manager fccm_checker u_fccm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/fat_chain_checker.sv -----
module fat_chain_checker #(
  parameter int MAX_CLUSTERS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [fccm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [fccm_pkg::DATA_W-1:0] s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [fccm_pkg::DATA_W-1:0] m_tdata,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fccm_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CLU_W-1:0] cluster;
  } fat_result_t;

  logic [EW-1:0] fat_shadow [MAX_CLUSTERS];
  logic          shadow_formatted;
  int unsigned   device_clusters;
  fat_result_t   expected_results [$];

  function automatic int unsigned working_count();
    return (device_clusters > MAX_CLUSTERS) ? MAX_CLUSTERS : device_clusters;
  endfunction

  // Applies one action to the shadow table and returns its result.
  function automatic fat_result_t apply_action(input logic [ACT_W-1:0] act,
                                               input logic [CLU_W-1:0] clu);
    fat_result_t   r;
    int unsigned   n;
    int unsigned   walked;
    int unsigned   cur;
    int            found;
    logic [EW-1:0] old;
    r = '0;
    n = working_count();
    found = -1;
    case (act)
      ACT_FORMAT: begin
        for (int i = 0; i < RESERVED_COUNT; i++) fat_shadow[i] = CODE_RSVD;
        fat_shadow[RESERVED_COUNT] = CODE_DIR;
        for (int i = FIRST_DATA; i < n; i++) fat_shadow[i] = CODE_FREE;
        shadow_formatted = 1'b1;
      end
      ACT_CHECK: begin
        shadow_formatted = (fat_shadow[RESERVED_COUNT] == CODE_DIR);
        for (int i = 0; i < RESERVED_COUNT; i++)
          if (fat_shadow[i] != CODE_RSVD) shadow_formatted = 1'b0;
        if (!shadow_formatted) r.status = ST_UNFORMATTED;
      end
      ACT_ALLOC, ACT_EXTEND: begin
        if (!shadow_formatted) begin
          r.status = ST_UNFORMATTED;
        end else begin
          for (int i = FIRST_DATA; i < n && found < 0; i++)
            if (fat_shadow[i] == CODE_FREE) found = i;
          if (found < 0) begin
            r.status = ST_FULL;
          end else begin
            // link first, end mark second: a tail that is itself the new cluster ends up END
            if (act == ACT_EXTEND && clu < MAX_CLUSTERS) fat_shadow[clu] = EW'(found);
            fat_shadow[found] = CODE_END;
            r.cluster = CLU_W'(found);
          end
        end
      end
      ACT_FREE: begin
        cur = clu;
        walked = 0;
        while (1'b1) begin
          if (cur >= MAX_CLUSTERS || walked >= n) begin
            r.status = ST_OVERRUN;
            break;
          end
          old = fat_shadow[cur];
          fat_shadow[cur] = CODE_FREE;
          walked++;
          if (old == CODE_END) break;
          cur = old;
        end
      end
      ACT_SUCC: begin
        if (clu < MAX_CLUSTERS) r.cluster = fat_shadow[clu][CLU_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    fat_result_t got;
    fat_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) fat_shadow[i] = '0;
      shadow_formatted = 1'b1;
      device_clusters = CIU_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wen) device_clusters = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[ST_W-1:0];
        got.cluster = m_tdata[ST_W +: CLU_W];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got status %0d cluster %0d",
                   $time, got.status, got.cluster);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
          end
          if (got.cluster !== want.cluster) begin
            errors++;
            $display("%0t: result_cluster mismatch, expected %0d, got %0d",
                     $time, want.cluster, got.cluster);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_action(s_tdata[ACT_W-1:0], s_tdata[ACT_W +: CLU_W]));
    end
    pending = expected_results.size();
  end

endmodule

// ----- tb/sv/fat_cluster_chain_manager_tb.sv -----
module fat_cluster_chain_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fccm_pkg::*;

  localparam int MAX_CLU        = 4096;
  localparam int HOLDOFF_CYCLES = 300;  // long receiver stall, fills the output register
  localparam int CHAIN_OPS      = 10;   // well-formed items per phase

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_wen   = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;   // [2:0] action, [14:3] cluster, [15] 0
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;          // [1:0] status, [13:2] result_cluster, [15:14] 0

  int errors;
  int pending;

  // Handshake between stimulus and receiver: stimulus asks, receiver serves.
  int holdoff_requests = 0;
  int holdoffs_served  = 0;
  bit steady_flow      = 1'b0;   // both sides run without gaps while set

  // Stimulus-side bookkeeping of live chains, used only to build well-formed
  // sequences (extend a real tail, free a real head). Reset on every format.
  bit in_use    [MAX_CLU];
  int link_next [MAX_CLU];
  int chain_head [$];
  int chain_tail [$];
  int data_limit = MAX_CLU;       // working cluster count of the current setting

  always #5 clk = ~clk;

  fat_cluster_chain_manager #(
    .MAX_CLUSTERS(MAX_CLU)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  fat_chain_checker #(
    .MAX_CLUSTERS(MAX_CLU)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Sender gap: mostly none or short, a few long.
  function automatic int idle_gap();
    int pick;
    if (steady_flow) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Offer one item at the falling edge and hold it until accepted.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [CLU_W-1:0] clu);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {1'b0, clu, act};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Register writes only while the block is idle: every item gives a result,
  // so no expected result left means nothing is in flight.
  task automatic write_config(input logic [CFG_W-1:0] value);
    s_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    cfg_wdata = value;
    cfg_wen   = 1'b1;
    @(negedge clk);
    cfg_wen   = 1'b0;
    data_limit = (value > MAX_CLU) ? MAX_CLU : int'(value);
  endtask

  function automatic int lowest_free();
    for (int i = FIRST_DATA; i < data_limit; i++)
      if (!in_use[i]) return i;
    return -1;
  endfunction

  task automatic format_table();
    send_item(ACT_FORMAT, CLU_W'($urandom));
    for (int i = 0; i < MAX_CLU; i++) in_use[i] = 1'b0;
    chain_head.delete();
    chain_tail.delete();
  endtask

  // k < 0 starts a new chain, otherwise chain k gets a new tail.
  task automatic grow_chain(input int k);
    int f;
    f = lowest_free();
    if (k < 0) send_item(ACT_ALLOC, CLU_W'($urandom));
    else       send_item(ACT_EXTEND, CLU_W'(chain_tail[k]));
    if (f >= 0) begin
      in_use[f] = 1'b1;
      if (k < 0) begin
        chain_head.push_back(f);
        chain_tail.push_back(f);
      end else begin
        link_next[chain_tail[k]] = f;
        chain_tail[k] = f;
      end
    end
  endtask

  task automatic drop_chain(input int k);
    int c;
    c = chain_head[k];
    send_item(ACT_FREE, CLU_W'(c));
    while (1'b1) begin
      in_use[c] = 1'b0;
      if (c == chain_tail[k]) break;
      c = link_next[c];
    end
    chain_head.delete(k);
    chain_tail.delete(k);
  endtask

  // One well-formed item with random content; a little harmless noise mixed in.
  task automatic chain_op();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (chain_head.size() == 0 || pick < 30) begin
      grow_chain(-1);
    end else begin
      k = $urandom_range(0, chain_head.size() - 1);
      if (pick < 62)      grow_chain(k);
      else if (pick < 78) drop_chain(k);
      else if (pick < 92) send_item(ACT_SUCC, CLU_W'(pick[0] ? chain_head[k] : chain_tail[k]));
      else if (pick < 96) send_item(ACT_CHECK, CLU_W'($urandom));
      else                send_item(ACT_W'($urandom_range(6, 7)), CLU_W'($urandom));
    end
  endtask

  // One setting of the cluster count: format, a run of chain work, then
  // destructive noise (random links and frees, a link into the reserved
  // area) closed by a check. pre_noise hits the table before formatting,
  // which after a failed check gives the not-formatted status.
  task automatic run_phase(input logic [CFG_W-1:0] count, input bit with_holdoff,
                           input bit pre_noise);
    write_config(count);
    if (pre_noise) begin
      send_item(ACT_ALLOC, CLU_W'($urandom));
      send_item(ACT_SUCC, CLU_W'($urandom));
    end
    format_table();
    if (with_holdoff) begin
      // receiver stalls while the sender keeps offering back to back
      steady_flow = 1'b1;
      holdoff_requests++;
    end
    for (int j = 0; j < CHAIN_OPS; j++) begin
      if (j == 6) steady_flow = 1'b0;
      chain_op();
    end
    steady_flow = 1'b0;
    send_item(ACT_EXTEND, CLU_W'($urandom));
    send_item(ACT_FREE, CLU_W'($urandom));
    send_item(ACT_EXTEND, CLU_W'($urandom_range(0, RESERVED_COUNT)));
    send_item(ACT_CHECK, CLU_W'($urandom));
  endtask

  // Receiver: random ready pattern, long hold-offs on request.
  initial begin : receiver
    int pick;
    int span;
    wait (!rst);
    forever begin
      if (holdoff_requests != holdoffs_served) begin
        m_tready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoffs_served++;
      end else begin
        pick = $urandom_range(0, 99);
        if (steady_flow || pick < 60) begin
          m_tready = 1'b1;
          span = $urandom_range(1, 16);
        end else if (pick < 92) begin
          m_tready = 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          m_tready = 1'b0;
          span = $urandom_range(15, 50);
        end
        repeat (span) @(negedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Out of reset: table all zero but the formatted flag set.
    send_item(ACT_ALLOC, 12'd4095);        // nothing free in a zero table
    send_item(ACT_SUCC, 12'd0);
    send_item(ACT_CHECK, 12'd0);           // zero table fails the check, flag drops
    send_item(ACT_EXTEND, 12'd33);         // refused, not formatted
    send_item(ACT_ALLOC, 12'd0);
    send_item(ACT_W'(6), 12'd4095);        // unused action code
    send_item(ACT_FREE, 12'd4095);         // walk loops through zeros until overrun

    // Register beyond the table size: working count clamps to the table.
    write_config(13'd8191);
    send_item(ACT_FORMAT, 12'd4095);
    send_item(ACT_CHECK, 12'd0);
    send_item(ACT_ALLOC, 12'd0);           // first data cluster
    send_item(ACT_EXTEND, 12'd33);
    send_item(ACT_EXTEND, 12'd34);
    send_item(ACT_EXTEND, 12'd4095);       // tail at the top entry of the table
    send_item(ACT_FREE, 12'd4095);
    send_item(ACT_FREE, 12'd33);           // three-cluster chain
    send_item(ACT_SUCC, 12'd35);           // released entry reads free
    send_item(ACT_FREE, 12'd3);            // reserved entry points at itself: overrun
    send_item(ACT_CHECK, 12'd0);           // reserved area now broken

    // Smallest count with any data area: exactly one data cluster.
    write_config(13'd34);
    send_item(ACT_FORMAT, 12'd0);
    send_item(ACT_ALLOC, 12'd0);
    send_item(ACT_ALLOC, 12'd0);           // table full
    send_item(ACT_FREE, 12'd33);

    // Zero count: no data area, free walk overruns at once.
    write_config(13'd0);
    send_item(ACT_FORMAT, 12'd0);
    send_item(ACT_ALLOC, 12'd0);
    send_item(ACT_FREE, 12'd33);
    send_item(ACT_CHECK, 12'd0);

    // Random phases across several settings; small counts keep scans short.
    run_phase(13'd40, 1'b1, 1'b0);
    run_phase(CFG_W'($urandom_range(35, 120)), 1'b0, 1'b1);
    run_phase(13'd33, 1'b0, 1'b1);         // formatted but no data cluster at all
    run_phase(13'd4096, 1'b0, 1'b1);
    run_phase(CFG_W'($urandom_range(34, 64)), 1'b0, 1'b1);
    run_phase(CFG_W'($urandom_range(100, 300)), 1'b0, 1'b1);
    run_phase(13'd34, 1'b0, 1'b1);

    // Drain, then a short quiet window to catch stray results.
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Timeout: several times the slowest legal run (full-table walks on every item).
  initial begin : watchdog
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
